FILE: hdl/tpzs_pkg.sv
package tpzs_pkg;

  localparam int COLUMNS      = 80;
  localparam int ROWS         = 22;
  localparam int CELLS        = ROWS * COLUMNS;
  localparam int CELL_BITS    = 11;
  localparam int ANGLE_BITS   = 10;
  localparam int QUARTER_BITS = ANGLE_BITS - 2;
  localparam int QUARTER      = 1 << QUARTER_BITS;
  localparam int DEPTH_BITS   = 16;
  localparam int SHADE_BITS   = 4;
  localparam int SIN_BITS     = 16;
  localparam int Q            = 14;
  localparam int ONE_Q14      = 1 << Q;
  localparam int VIEW_OFFSET  = 5 * ONE_Q14;
  localparam int X_CENTER     = 40;
  localparam int Y_CENTER     = 12;
  localparam int SHADE_MAX    = 11;
  localparam int DIV_STEPS    = DEPTH_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);
  localparam int STEP_BITS    = 5;
  localparam int DP_W         = 20;
  localparam int STORE_W      = DEPTH_BITS + SHADE_BITS;

  localparam logic [SHADE_BITS-1:0] BLANK_CODE = SHADE_BITS'(12);
  localparam logic [6:0]            SPACE_CHAR = 7'd32;

  // Sequencer steps of the shared multiplier / adder datapath
  localparam logic [STEP_BITS-1:0] ST_H   = 5'd0;
  localparam logic [STEP_BITS-1:0] ST_CH  = 5'd1;
  localparam logic [STEP_BITS-1:0] ST_CD  = 5'd2;
  localparam logic [STEP_BITS-1:0] ST_LH  = 5'd3;
  localparam logic [STEP_BITS-1:0] ST_LD  = 5'd4;
  localparam logic [STEP_BITS-1:0] ST_FE  = 5'd5;
  localparam logic [STEP_BITS-1:0] ST_FG  = 5'd6;
  localparam logic [STEP_BITS-1:0] ST_CHE = 5'd7;
  localparam logic [STEP_BITS-1:0] ST_DN  = 5'd8;
  localparam logic [STEP_BITS-1:0] ST_CHG = 5'd9;
  localparam logic [STEP_BITS-1:0] ST_T   = 5'd10;
  localparam logic [STEP_BITS-1:0] ST_LHM = 5'd11;
  localparam logic [STEP_BITS-1:0] ST_TN  = 5'd12;
  localparam logic [STEP_BITS-1:0] ST_PX  = 5'd13;
  localparam logic [STEP_BITS-1:0] ST_LHN = 5'd14;
  localparam logic [STEP_BITS-1:0] ST_TM  = 5'd15;
  localparam logic [STEP_BITS-1:0] ST_PY  = 5'd16;
  localparam logic [STEP_BITS-1:0] ST_CDG = 5'd17;
  localparam logic [STEP_BITS-1:0] ST_A   = 5'd18;
  localparam logic [STEP_BITS-1:0] ST_AM  = 5'd19;
  localparam logic [STEP_BITS-1:0] ST_CDE = 5'd20;
  localparam logic [STEP_BITS-1:0] ST_L1  = 5'd21;
  localparam logic [STEP_BITS-1:0] ST_LDN = 5'd22;
  localparam logic [STEP_BITS-1:0] ST_L2  = 5'd23;
  localparam logic [STEP_BITS-1:0] ST_Q   = 5'd24;
  localparam logic [STEP_BITS-1:0] ST_X   = 5'd25;
  localparam logic [STEP_BITS-1:0] ST_Y   = 5'd26;

  typedef struct packed {
    logic                 load;
    logic                 step_en;
    logic [STEP_BITS-1:0] step;
    logic                 div_init;
    logic                 div_iter;
    logic                 rd_issue;
    logic                 finish;
    logic                 clear;
    logic [CELL_BITS-1:0] clear_addr;
  } cmd_t;

  // Quarter-wave sine entry in Q14, evaluated at elaboration
  function automatic logic [14:0] sin_entry(input int unsigned r);
    logic [63:0] x;
    logic [63:0] th;
    logic [63:0] t2;
    logic [63:0] s;
    x  = 64'(r) << (28 - QUARTER_BITS);
    th = (x * 64'd421657428) >> 28;
    t2 = (th * th) >> 28;
    s  = 64'd268435456;
    s  = 64'd268435456 - ((t2 * s) >> 28) / 64'd72;
    s  = 64'd268435456 - ((t2 * s) >> 28) / 64'd42;
    s  = 64'd268435456 - ((t2 * s) >> 28) / 64'd20;
    s  = 64'd268435456 - ((t2 * s) >> 28) / 64'd6;
    s  = (th * s) >> 28;
    return 15'((s + 64'd8192) >> 14);
  endfunction

  function automatic logic [6:0] shade_char(input logic [SHADE_BITS-1:0] code);
    logic [6:0] ch;
    unique case (code)
      4'd0:    ch = 7'd46;   // .
      4'd1:    ch = 7'd44;   // ,
      4'd2:    ch = 7'd45;   // -
      4'd3:    ch = 7'd126;  // ~
      4'd4:    ch = 7'd58;   // :
      4'd5:    ch = 7'd59;   // ;
      4'd6:    ch = 7'd61;   // =
      4'd7:    ch = 7'd33;   // !
      4'd8:    ch = 7'd42;   // *
      4'd9:    ch = 7'd35;   // #
      4'd10:   ch = 7'd36;   // $
      4'd11:   ch = 7'd64;   // @
      default: ch = SPACE_CHAR;
    endcase
    return ch;
  endfunction

endpackage

FILE: hdl/tpzs_in_if.sv
interface tpzs_in_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic [tpzs_pkg::ANGLE_BITS-1:0]  tube_angle;
  logic [tpzs_pkg::ANGLE_BITS-1:0]  ring_angle;
  logic [tpzs_pkg::ANGLE_BITS-1:0]  tilt_angle;
  logic [tpzs_pkg::ANGLE_BITS-1:0]  spin_angle;
  logic [tpzs_pkg::CELL_BITS-1:0]   cell_address;

  modport source (output valid, mode, tube_angle, ring_angle, tilt_angle, spin_angle,
                  cell_address, input ready);
  modport sink (input valid, mode, tube_angle, ring_angle, tilt_angle, spin_angle,
                cell_address, output ready);
endinterface

FILE: hdl/tpzs_out_if.sv
interface tpzs_out_if;
  logic                           valid;
  logic                           ready;
  logic                           plotted;
  logic [tpzs_pkg::CELL_BITS-1:0] cell_index;
  logic [6:0]                     character;

  modport source (output valid, plotted, cell_index, character, input ready);
  modport sink (input valid, plotted, cell_index, character, output ready);
endinterface

FILE: hdl/tpzs_ram.sv
module tpzs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/tpzs_ctrl.sv
module tpzs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_mode,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output tpzs_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_DIV,
    S_MEM,
    S_FINISH
  } state_t;

  state_t                                state;
  logic [tpzs_pkg::STEP_BITS-1:0]        seq_step;
  logic [tpzs_pkg::DIV_CNT_BITS-1:0]     div_cnt;
  logic [tpzs_pkg::CELL_BITS-1:0]        clr_cnt;
  logic                                  out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.load       = (state == S_IDLE) && in_valid;
    cmd.step_en    = (state == S_CALC);
    cmd.step       = seq_step;
    cmd.div_init   = (state == S_CALC) && (seq_step == tpzs_pkg::ST_L2);
    cmd.div_iter   = (state == S_DIV);
    cmd.rd_issue   = (state == S_MEM);
    cmd.finish     = (state == S_FINISH) && out_free;
    cmd.clear      = (state == S_CLEAR);
    cmd.clear_addr = clr_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      seq_step  <= tpzs_pkg::ST_H;
      div_cnt   <= '0;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      // Load a new result, or drop the one taken by the receiver
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_cnt == tpzs_pkg::CELL_BITS'(tpzs_pkg::CELLS - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_cnt <= clr_cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            seq_step <= tpzs_pkg::ST_H;
            state    <= in_mode ? S_MEM : S_CALC;
          end
        end
        S_CALC: begin
          if (seq_step == tpzs_pkg::ST_L2) begin
            div_cnt <= '0;
            state   <= S_DIV;
          end else if (seq_step == tpzs_pkg::ST_Y) begin
            state <= S_MEM;
          end else begin
            seq_step <= seq_step + 1'b1;
          end
        end
        S_DIV: begin
          if (div_cnt == tpzs_pkg::DIV_CNT_BITS'(tpzs_pkg::DIV_STEPS - 1)) begin
            seq_step <= tpzs_pkg::ST_Q;
            state    <= S_CALC;
          end else begin
            div_cnt <= div_cnt + 1'b1;
          end
        end
        S_MEM: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer accepted while an item is in flight");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FINISH)
    else $error("result raised outside finish");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !out_valid)
    else $error("result pending during clearing sweep");

endmodule

FILE: hdl/tpzs_dp.sv
module tpzs_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  tpzs_pkg::cmd_t                  cmd,
  input  logic                            sample_mode,
  input  logic [tpzs_pkg::ANGLE_BITS-1:0] tube_angle,
  input  logic [tpzs_pkg::ANGLE_BITS-1:0] ring_angle,
  input  logic [tpzs_pkg::ANGLE_BITS-1:0] tilt_angle,
  input  logic [tpzs_pkg::ANGLE_BITS-1:0] spin_angle,
  input  logic [tpzs_pkg::CELL_BITS-1:0]  cell_address,
  output logic                            plotted,
  output logic [tpzs_pkg::CELL_BITS-1:0]  cell_index,
  output logic [6:0]                      character
);

  logic [14:0] sin_rom [0:tpzs_pkg::QUARTER-1];

  for (genvar i = 0; i < tpzs_pkg::QUARTER; i++) begin : g_rom
    assign sin_rom[i] = tpzs_pkg::sin_entry(i);
  end

  function automatic logic signed [tpzs_pkg::SIN_BITS-1:0] sin_q14(
    input logic [tpzs_pkg::ANGLE_BITS-1:0] a
  );
    logic [1:0]                       quad;
    logic [tpzs_pkg::QUARTER_BITS:0]  ridx;
    logic [14:0]                      mag;
    quad = a[tpzs_pkg::ANGLE_BITS-1 -: 2];
    ridx = {1'b0, a[tpzs_pkg::QUARTER_BITS-1:0]};
    if (quad[0]) begin
      ridx = (tpzs_pkg::QUARTER_BITS+1)'(tpzs_pkg::QUARTER) - ridx;
    end
    if (ridx[tpzs_pkg::QUARTER_BITS]) begin
      mag = tpzs_pkg::sin_entry(tpzs_pkg::QUARTER);
    end else begin
      mag = sin_rom[ridx[tpzs_pkg::QUARTER_BITS-1:0]];
    end
    return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  function automatic logic [tpzs_pkg::ANGLE_BITS-1:0] quarter_on(
    input logic [tpzs_pkg::ANGLE_BITS-1:0] a
  );
    return a + tpzs_pkg::ANGLE_BITS'(tpzs_pkg::QUARTER);
  endfunction

  logic                                  mode;
  logic [tpzs_pkg::CELL_BITS-1:0]        addr;
  logic signed [tpzs_pkg::SIN_BITS-1:0]  c, l, d, f, e, g, m, n;
  logic signed [tpzs_pkg::DP_W-1:0]      h, ch, cd, lh, ld, fe, fg, dn, tt, px, py, tmp, lum;
  logic [20:0]                           q30;
  logic [19:0]                           q15;
  logic signed [11:0]                    x, y;
  logic [18:0]                           rem;
  logic [tpzs_pkg::DEPTH_BITS-1:0]       quo;
  logic                                  sat;

  logic signed [23:0] mul_a, mul_b;
  logic signed [47:0] prod;
  logic signed [tpzs_pkg::DP_W-1:0] pq;
  logic [19:0]        rem_dbl;
  logic [19:0]        dn_u;
  logic [tpzs_pkg::DEPTH_BITS-1:0] dq;

  assign prod    = mul_a * mul_b;
  assign pq      = prod[tpzs_pkg::DP_W+tpzs_pkg::Q-1:tpzs_pkg::Q];
  assign rem_dbl = {rem, 1'b0};
  assign dn_u    = dn;
  assign dq      = sat ? '1 : quo;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.step)
      tpzs_pkg::ST_CH:  begin mul_a = 24'(c);  mul_b = 24'(h); end
      tpzs_pkg::ST_CD:  begin mul_a = 24'(c);  mul_b = 24'(d); end
      tpzs_pkg::ST_LH:  begin mul_a = 24'(l);  mul_b = 24'(h); end
      tpzs_pkg::ST_LD:  begin mul_a = 24'(l);  mul_b = 24'(d); end
      tpzs_pkg::ST_FE:  begin mul_a = 24'(f);  mul_b = 24'(e); end
      tpzs_pkg::ST_FG:  begin mul_a = 24'(f);  mul_b = 24'(g); end
      tpzs_pkg::ST_CHE: begin mul_a = 24'(ch); mul_b = 24'(e); end
      tpzs_pkg::ST_CHG: begin mul_a = 24'(ch); mul_b = 24'(g); end
      tpzs_pkg::ST_LHM: begin mul_a = 24'(lh); mul_b = 24'(m); end
      tpzs_pkg::ST_TN:  begin mul_a = 24'(tt); mul_b = 24'(n); end
      tpzs_pkg::ST_LHN: begin mul_a = 24'(lh); mul_b = 24'(n); end
      tpzs_pkg::ST_TM:  begin mul_a = 24'(tt); mul_b = 24'(m); end
      tpzs_pkg::ST_CDG: begin mul_a = 24'(cd); mul_b = 24'(g); end
      tpzs_pkg::ST_AM:  begin mul_a = 24'(tmp); mul_b = 24'(m); end
      tpzs_pkg::ST_CDE: begin mul_a = 24'(cd); mul_b = 24'(e); end
      tpzs_pkg::ST_LDN: begin mul_a = 24'(ld); mul_b = 24'(n); end
      tpzs_pkg::ST_X:   begin mul_a = $signed({3'b000, q30}); mul_b = 24'(px); end
      tpzs_pkg::ST_Y:   begin mul_a = $signed({4'b0000, q15}); mul_b = 24'(py); end
      default: ;
    endcase
  end

  // Cell test and shade
  logic                           in_frame;
  logic [tpzs_pkg::CELL_BITS-1:0] cell_addr;
  logic signed [8:0]              shade_raw;
  logic [tpzs_pkg::SHADE_BITS-1:0] shade;
  logic                           addr_ok;

  assign in_frame = (y > 12'sd0) && (y < 12'(tpzs_pkg::ROWS))
                 && (x > 12'sd0) && (x < 12'(tpzs_pkg::COLUMNS));
  assign cell_addr = tpzs_pkg::CELL_BITS'(16'(x) + 16'(y) * 16'(tpzs_pkg::COLUMNS));
  assign shade_raw = lum[tpzs_pkg::DP_W-1:tpzs_pkg::Q-3];
  assign addr_ok   = addr < tpzs_pkg::CELL_BITS'(tpzs_pkg::CELLS);

  always_comb begin
    if (shade_raw < 9'sd0) begin
      shade = '0;
    end else if (shade_raw > 9'(tpzs_pkg::SHADE_MAX)) begin
      shade = tpzs_pkg::SHADE_BITS'(tpzs_pkg::SHADE_MAX);
    end else begin
      shade = shade_raw[tpzs_pkg::SHADE_BITS-1:0];
    end
  end

  // Depth and shade store, one word per cell
  logic                            ram_we;
  logic [tpzs_pkg::CELL_BITS-1:0]  ram_waddr;
  logic [tpzs_pkg::STORE_W-1:0]    ram_wdata;
  logic [tpzs_pkg::CELL_BITS-1:0]  ram_raddr;
  logic [tpzs_pkg::STORE_W-1:0]    ram_rdata;
  logic [tpzs_pkg::DEPTH_BITS-1:0] rd_depth;
  logic [tpzs_pkg::SHADE_BITS-1:0] rd_shade;
  logic                            wr_ok;

  assign rd_depth  = ram_rdata[tpzs_pkg::STORE_W-1:tpzs_pkg::SHADE_BITS];
  assign rd_shade  = ram_rdata[tpzs_pkg::SHADE_BITS-1:0];
  assign wr_ok     = mode ? addr_ok : (in_frame && (dq > rd_depth));
  assign ram_we    = cmd.clear || (cmd.finish && wr_ok);
  assign ram_waddr = cmd.clear ? cmd.clear_addr : (mode ? addr : cell_addr);
  assign ram_wdata = (cmd.clear || mode) ? {{tpzs_pkg::DEPTH_BITS{1'b0}}, tpzs_pkg::BLANK_CODE}
                                         : {dq, shade};
  assign ram_raddr = mode ? addr : cell_addr;

  tpzs_ram #(
    .WIDTH (tpzs_pkg::STORE_W),
    .DEPTH (tpzs_pkg::CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_issue),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode <= sample_mode;
      addr <= cell_address;
      c    <= sin_q14(ring_angle);
      l    <= sin_q14(quarter_on(ring_angle));
      d    <= sin_q14(quarter_on(tube_angle));
      f    <= sin_q14(tube_angle);
      e    <= sin_q14(tilt_angle);
      g    <= sin_q14(quarter_on(tilt_angle));
      m    <= sin_q14(quarter_on(spin_angle));
      n    <= sin_q14(spin_angle);
    end
    if (cmd.step_en) begin
      case (cmd.step)
        tpzs_pkg::ST_H:   h   <= tpzs_pkg::DP_W'(d) + tpzs_pkg::DP_W'(2 * tpzs_pkg::ONE_Q14);
        tpzs_pkg::ST_CH:  ch  <= pq;
        tpzs_pkg::ST_CD:  cd  <= pq;
        tpzs_pkg::ST_LH:  lh  <= pq;
        tpzs_pkg::ST_LD:  ld  <= pq;
        tpzs_pkg::ST_FE:  fe  <= pq;
        tpzs_pkg::ST_FG:  fg  <= pq;
        tpzs_pkg::ST_CHE: dn  <= pq;
        tpzs_pkg::ST_DN:  dn  <= dn + fg + tpzs_pkg::DP_W'(tpzs_pkg::VIEW_OFFSET);
        tpzs_pkg::ST_CHG: tt  <= pq;
        tpzs_pkg::ST_T:   tt  <= tt - fe;
        tpzs_pkg::ST_LHM: px  <= pq;
        tpzs_pkg::ST_TN:  tmp <= pq;
        tpzs_pkg::ST_PX:  px  <= px - tmp;
        tpzs_pkg::ST_LHN: py  <= pq;
        tpzs_pkg::ST_TM:  tmp <= pq;
        tpzs_pkg::ST_PY:  py  <= py + tmp;
        tpzs_pkg::ST_CDG: tmp <= pq;
        tpzs_pkg::ST_A:   tmp <= fe - tmp;
        tpzs_pkg::ST_AM:  lum <= pq;
        tpzs_pkg::ST_CDE: tmp <= pq;
        tpzs_pkg::ST_L1:  lum <= lum - tmp - fg;
        tpzs_pkg::ST_LDN: tmp <= pq;
        tpzs_pkg::ST_L2:  lum <= lum - tmp;
        tpzs_pkg::ST_Q: begin
          q30 <= 21'({dq, 5'b0}) - 21'({dq, 1'b0});
          q15 <= 20'({dq, 4'b0}) - 20'(dq);
        end
        tpzs_pkg::ST_X:   x <= 12'(tpzs_pkg::X_CENTER) + $signed(prod[41:30]);
        tpzs_pkg::ST_Y:   y <= 12'(tpzs_pkg::Y_CENTER) + $signed(prod[41:30]);
        default: ;
      endcase
    end
    // Any denominator at or below one in Q14 saturates the inverse depth
    if (cmd.div_init) begin
      rem <= 19'(tpzs_pkg::ONE_Q14);
      quo <= '0;
      sat <= (dn <= tpzs_pkg::DP_W'(tpzs_pkg::ONE_Q14));
    end
    if (cmd.div_iter) begin
      if (rem_dbl >= dn_u) begin
        rem <= 19'(rem_dbl - dn_u);
        quo <= {quo[tpzs_pkg::DEPTH_BITS-2:0], 1'b1};
      end else begin
        rem <= rem_dbl[18:0];
        quo <= {quo[tpzs_pkg::DEPTH_BITS-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      plotted    <= !mode && wr_ok;
      cell_index <= mode ? addr : (wr_ok ? cell_addr : '0);
      character  <= (mode && addr_ok) ? tpzs_pkg::shade_char(rd_shade) : tpzs_pkg::SPACE_CHAR;
    end
  end

  a_nearer_wins: assert property (@(posedge clk) disable iff (rst)
    ram_we && !cmd.clear && !mode |-> dq > rd_depth && in_frame)
    else $error("plot write without passing depth test");

  a_clear_writes_blank: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> ram_we && ram_wdata == {{tpzs_pkg::DEPTH_BITS{1'b0}}, tpzs_pkg::BLANK_CODE})
    else $error("clearing sweep did not write an empty cell");

  a_read_never_plots: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && mode |=> !plotted)
    else $error("read result flagged as plotted");

endmodule

FILE: hdl/torus_point_zbuffer_shader_top.sv
// Torus point z-buffer shader.
// Input channel "sample" (valid/ready): mode 0 plots one torus surface sample
// given by tube, ring, tilt and spin phase codes (1024 per turn); mode 1 reads
// the ASCII shade of cell_address (row*80+column) and clears that cell.
// Output channel "result" (valid/ready) returns exactly one item per sample:
// plotted, cell_index and character.
// A plot runs from the input transfer to the result through 24 steps on
// the shared multiplier and adder, a restoring divide for the inverse depth
// that yields one quotient bit per cycle, 3 projection steps, then a read
// and a write of the cell store; a read skips the steps and the divide.
// The block takes no new sample until the result of the last one is
// loaded; it is ready again in the same cycle as that result turns valid.
// After reset the block sweeps the store, setting every cell to empty;
// sample.ready stays low during the sweep.
// A held result does not block the next sample: the block accepts it and
// works on it, and waits only when its own result is ready while the
// previous one has not yet been taken.
module torus_point_zbuffer_shader_top (
  input  logic              clk,
  input  logic              rst,
  tpzs_in_if.sink           sample,
  tpzs_out_if.source        result
);

  tpzs_pkg::cmd_t cmd;

  tpzs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_mode   (sample.mode),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  tpzs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sample_mode  (sample.mode),
    .tube_angle   (sample.tube_angle),
    .ring_angle   (sample.ring_angle),
    .tilt_angle   (sample.tilt_angle),
    .spin_angle   (sample.spin_angle),
    .cell_address (sample.cell_address),
    .plotted      (result.plotted),
    .cell_index   (result.cell_index),
    .character    (result.character)
  );

endmodule

FILE: bench/torus_point_zbuffer_shader_top_tb.sv
`timescale 1ns / 1ps

module torus_point_zbuffer_shader_top_tb;

  typedef struct {
    logic                            mode;
    logic [tpzs_pkg::ANGLE_BITS-1:0] tube;
    logic [tpzs_pkg::ANGLE_BITS-1:0] ring;
    logic [tpzs_pkg::ANGLE_BITS-1:0] tilt;
    logic [tpzs_pkg::ANGLE_BITS-1:0] spin;
    logic [tpzs_pkg::CELL_BITS-1:0]  addr;
    logic                            known;
    logic                            exp_plotted;
    logic [tpzs_pkg::CELL_BITS-1:0]  exp_cell;
    logic [6:0]                      exp_char;
  } sample_row_t;

  typedef struct {
    logic                           plotted;
    logic [tpzs_pkg::CELL_BITS-1:0] cell_idx;
    logic [6:0]                     character;
  } cell_result_t;

  localparam logic MODE_PLOT = 1'b0;
  localparam logic MODE_READ = 1'b1;
  localparam int   N_RANDOM  = 1000;
  localparam int   STALL_LIMIT = 20000;

  logic clk;
  logic rst;

  tpzs_in_if  sample ();
  tpzs_out_if result ();

  torus_point_zbuffer_shader_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample.sink),
    .result (result.source)
  );

  logic [tpzs_pkg::DEPTH_BITS-1:0] depth_mirror [tpzs_pkg::CELLS];
  logic [tpzs_pkg::SHADE_BITS-1:0] shade_mirror [tpzs_pkg::CELLS];
  cell_result_t          pending_results [$];
  cell_result_t          directed_results [$];
  logic                  directed_known [$];
  int                    mismatches;
  int                    idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint floor_shr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint mul14(input longint a, input longint b);
    return floor_shr(a * b, tpzs_pkg::Q);
  endfunction

  function automatic longint sine14(input int unsigned a);
    int unsigned quad, r;
    longint unsigned x, th, t2, s;
    longint v;
    a = a & ((1 << tpzs_pkg::ANGLE_BITS) - 1);
    quad = a >> tpzs_pkg::QUARTER_BITS;
    r = a & (tpzs_pkg::QUARTER - 1);
    if (quad & 1) r = tpzs_pkg::QUARTER - r;
    x = longint'(r) << (28 - tpzs_pkg::QUARTER_BITS);
    th = (x * 64'd421657428) >> 28;
    t2 = (th * th) >> 28;
    s = 64'd268435456;
    s = 64'd268435456 - ((t2 * s) >> 28) / 72;
    s = 64'd268435456 - ((t2 * s) >> 28) / 42;
    s = 64'd268435456 - ((t2 * s) >> 28) / 20;
    s = 64'd268435456 - ((t2 * s) >> 28) / 6;
    s = (th * s) >> 28;
    v = longint'((s + 64'd8192) >> 14);
    return (quad & 2) ? -v : v;
  endfunction

  function automatic longint cosine14(input int unsigned a);
    return sine14(a + tpzs_pkg::QUARTER);
  endfunction

  function automatic logic [6:0] glyph(input logic [tpzs_pkg::SHADE_BITS-1:0] code);
    case (code)
      4'd0: return 7'd46;
      4'd1: return 7'd44;
      4'd2: return 7'd45;
      4'd3: return 7'd126;
      4'd4: return 7'd58;
      4'd5: return 7'd59;
      4'd6: return 7'd61;
      4'd7: return 7'd33;
      4'd8: return 7'd42;
      4'd9: return 7'd35;
      4'd10: return 7'd36;
      4'd11: return 7'd64;
      default: return tpzs_pkg::SPACE_CHAR;
    endcase
  endfunction

  function automatic cell_result_t render_sample(input sample_row_t s);
    cell_result_t res;
    longint c, l, d, f, e, g, m, n, h, ch, t, denom, px, py, lh, cd, lum, x, y, shade;
    longint unsigned dq, cap;
    int sh;
    int cell_no;
    sh = tpzs_pkg::DEPTH_BITS + tpzs_pkg::Q;
    res.plotted = 1'b0;
    res.cell_idx = '0;
    res.character = tpzs_pkg::SPACE_CHAR;
    if (s.mode == MODE_READ) begin
      res.cell_idx = s.addr;
      if (s.addr < tpzs_pkg::CELLS) begin
        res.character = glyph(shade_mirror[s.addr]);
        depth_mirror[s.addr] = '0;
        shade_mirror[s.addr] = tpzs_pkg::BLANK_CODE;
      end
      return res;
    end
    c = sine14(s.ring);
    l = cosine14(s.ring);
    d = cosine14(s.tube);
    f = sine14(s.tube);
    e = sine14(s.tilt);
    g = cosine14(s.tilt);
    m = cosine14(s.spin);
    n = sine14(s.spin);
    h = d + 2 * tpzs_pkg::ONE_Q14;
    ch = mul14(c, h);
    denom = mul14(ch, e) + mul14(f, g) + tpzs_pkg::VIEW_OFFSET;
    if (denom < 1) denom = 1;
    dq = (64'd1 << sh) / longint'(denom);
    cap = (64'd1 << tpzs_pkg::DEPTH_BITS) - 1;
    if (dq > cap) dq = cap;
    t = mul14(ch, g) - mul14(f, e);
    lh = mul14(l, h);
    px = mul14(lh, m) - mul14(t, n);
    py = mul14(lh, n) + mul14(t, m);
    x = floor_shr((longint'(tpzs_pkg::X_CENTER) << sh) + 30 * longint'(dq) * px, sh);
    y = floor_shr((longint'(tpzs_pkg::Y_CENTER) << sh) + 15 * longint'(dq) * py, sh);
    cd = mul14(c, d);
    lum = mul14(mul14(f, e) - mul14(cd, g), m)
        - mul14(cd, e) - mul14(f, g) - mul14(mul14(l, d), n);
    shade = floor_shr(8 * lum, tpzs_pkg::Q);
    if (shade < 0) shade = 0;
    if (shade > tpzs_pkg::SHADE_MAX) shade = tpzs_pkg::SHADE_MAX;
    if (y > 0 && y < tpzs_pkg::ROWS && x > 0 && x < tpzs_pkg::COLUMNS) begin
      cell_no = int'(x + tpzs_pkg::COLUMNS * y);
      if (cell_no < tpzs_pkg::CELLS && dq > depth_mirror[cell_no]) begin
        depth_mirror[cell_no] = tpzs_pkg::DEPTH_BITS'(dq);
        shade_mirror[cell_no] = tpzs_pkg::SHADE_BITS'(shade);
        res.plotted = 1'b1;
        res.cell_idx = tpzs_pkg::CELL_BITS'(cell_no);
      end
    end
    return res;
  endfunction

  function automatic sample_row_t mk(input logic md, input int tu, input int ri, input int ti,
                                     input int sp, input int ad);
    sample_row_t r;
    r.mode = md;
    r.tube = tpzs_pkg::ANGLE_BITS'(tu);
    r.ring = tpzs_pkg::ANGLE_BITS'(ri);
    r.tilt = tpzs_pkg::ANGLE_BITS'(ti);
    r.spin = tpzs_pkg::ANGLE_BITS'(sp);
    r.addr = tpzs_pkg::CELL_BITS'(ad);
    r.known = 1'b0;
    r.exp_plotted = 1'b0;
    r.exp_cell = '0;
    r.exp_char = tpzs_pkg::SPACE_CHAR;
    return r;
  endfunction

  function automatic sample_row_t mk_read(input int ad, input logic [6:0] chr);
    sample_row_t r;
    r = mk(MODE_READ, 1023, 0, 1023, 0, ad);
    r.known = 1'b1;
    r.exp_cell = tpzs_pkg::CELL_BITS'(ad);
    r.exp_char = chr;
    return r;
  endfunction

  sample_row_t directed [$];

  task automatic send(input sample_row_t s);
    cell_result_t r;
    int gap;
    gap = $urandom_range(0, 7);
    if (gap > 0) begin
      sample.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample.valid <= 1'b1;
    sample.mode <= s.mode;
    sample.tube_angle <= s.tube;
    sample.ring_angle <= s.ring;
    sample.tilt_angle <= s.tilt;
    sample.spin_angle <= s.spin;
    sample.cell_address <= s.addr;
    do @(posedge clk); while (!sample.ready);
    r = render_sample(s);
    pending_results.push_back(r);
    directed_known.push_back(s.known);
    if (s.known) begin
      r.plotted = s.exp_plotted;
      r.cell_idx = s.exp_cell;
      r.character = s.exp_char;
    end
    directed_results.push_back(r);
  endtask

  // Receive side: random stall per result, compare against oldest expectation
  initial begin
    int stall;
    cell_result_t want, typed;
    logic typed_ok;
    forever begin
      stall = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        result.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!result.valid);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
      end else begin
        want = pending_results.pop_front();
        typed = directed_results.pop_front();
        typed_ok = directed_known.pop_front();
        if (result.plotted !== want.plotted || result.cell_index !== want.cell_idx ||
            result.character !== want.character ||
            (typed_ok && (result.plotted !== typed.plotted ||
             result.cell_index !== typed.cell_idx ||
             result.character !== typed.character))) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp plotted=%0d cell=%0d char=%0d got %0d %0d %0d",
                     want.plotted, want.cell_idx, want.character,
                     result.plotted, result.cell_index, result.character);
        end
      end
    end
  end

  // Watchdog on transfer-free cycles
  always @(posedge clk) begin
    if (rst || (sample.valid && sample.ready) || (result.valid && result.ready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[torus_point_zbuffer_shader_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    sample_row_t s;
    int k, base_tilt, base_spin;
    mismatches = 0;
    for (int i = 0; i < tpzs_pkg::CELLS; i++) begin
      depth_mirror[i] = '0;
      shade_mirror[i] = tpzs_pkg::BLANK_CODE;
    end
    rst <= 1'b1;
    sample.valid <= 1'b0;
    sample.mode <= MODE_PLOT;
    sample.tube_angle <= '0;
    sample.ring_angle <= '0;
    sample.tilt_angle <= '0;
    sample.spin_angle <= '0;
    sample.cell_address <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty store reads as space; out-of-range and all-ones addresses echo
    directed.push_back(mk_read(0, tpzs_pkg::SPACE_CHAR));
    directed.push_back(mk_read(tpzs_pkg::CELLS - 1, tpzs_pkg::SPACE_CHAR));
    directed.push_back(mk_read(tpzs_pkg::CELLS, tpzs_pkg::SPACE_CHAR));
    directed.push_back(mk_read(2047, tpzs_pkg::SPACE_CHAR));
    directed.push_back(mk(MODE_PLOT, 0, 0, 0, 0, 0));
    directed.push_back(mk(MODE_PLOT, 1023, 1023, 1023, 1023, 2047));
    directed.push_back(mk(MODE_PLOT, 256, 256, 256, 256, 0));
    directed.push_back(mk(MODE_PLOT, 512, 768, 128, 900, 0));
    directed.push_back(mk(MODE_PLOT, 0, 256, 768, 0, 0));
    directed.push_back(mk(MODE_PLOT, 768, 0, 256, 512, 0));
    directed.push_back(mk(MODE_PLOT, 100, 200, 300, 400, 0));
    directed.push_back(mk(MODE_PLOT, 100, 200, 300, 400, 0));
    directed.push_back(mk(MODE_PLOT, 600, 50, 700, 1000, 0));
    for (int a = 0; a < 8; a++) directed.push_back(mk(MODE_READ, 0, 0, 0, 0, 40 + 80 * (9 + a)));
    foreach (directed[i]) send(directed[i]);

    // One frame per group: surface samples at a fixed rotation (one in ten fully random), then read-out
    k = 0;
    while (k < N_RANDOM) begin
      base_tilt = $urandom_range(0, 1023);
      base_spin = $urandom_range(0, 1023);
      repeat (40) begin
        if ($urandom_range(0, 9) == 0)
          s = mk(1'($urandom_range(0, 1)), $urandom_range(0, 1023), $urandom_range(0, 1023),
                 $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 2047));
        else
          s = mk(MODE_PLOT, $urandom_range(0, 1023), $urandom_range(0, 1023),
                 base_tilt, base_spin, $urandom_range(0, 2047));
        send(s);
        k++;
      end
      repeat (10) begin
        if ($urandom_range(0, 7) == 0) send(mk(MODE_READ, 0, 0, 0, 0, $urandom_range(0, 2047)));
        else send(mk(MODE_READ, 0, 0, 0, 0, $urandom_range(81, tpzs_pkg::CELLS - 1)));
        k++;
      end
    end
    sample.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0)
      $display("[torus_point_zbuffer_shader_top] OK");
    else
      $display("[torus_point_zbuffer_shader_top] ERROR");
    $finish;
  end

endmodule

FILE: files.f
hdl/tpzs_pkg.sv
hdl/tpzs_in_if.sv
hdl/tpzs_out_if.sv
hdl/tpzs_ram.sv
hdl/tpzs_ctrl.sv
hdl/tpzs_dp.sv
hdl/torus_point_zbuffer_shader_top.sv
bench/torus_point_zbuffer_shader_top_tb.sv
